FILE: hw/rtl/fraction_add_reduce_macros.svh
// Assertion macros used by the fraction adder top level.
`ifndef FRACTION_ADD_REDUCE_MACROS_SVH
`define FRACTION_ADD_REDUCE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FAR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fraction_add_reduce: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fraction_add_reduce: next-cycle check failed");

`endif

FILE: hw/rtl/far_pkg.sv
// Package with widths, microcode formats and the control program of the fraction adder.
`timescale 1ns / 1ps

package far_pkg;

    localparam int WIDTH   = 16;
    localparam int PROD_W  = 2 * WIDTH;
    localparam int DEN_W   = 2 * WIDTH - 2;
    localparam int REM_W   = PROD_W + 1;
    localparam int SHIFT_W = $clog2(PROD_W);
    localparam int CNT_W   = $clog2(PROD_W);
    localparam int PC_W    = 4;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MUL_P,
        OP_MUL_Q,
        OP_MUL_D,
        OP_SUM,
        OP_GINIT,
        OP_GSHIFT,
        OP_GSTEP,
        OP_DINIT,
        OP_DSTEP,
        OP_EMIT_OK,
        OP_EMIT_ERR,
        OP_EMIT_ZERO
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDLE,
        C_DEN_ZERO,
        C_MAG_ZERO,
        C_BOTH_EVEN,
        C_A_NONZERO,
        C_DIV_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic den_zero;
        logic mag_zero;
        logic both_even;
        logic a_nonzero;
        logic div_more;
    } flags_t;

    localparam pc_t PC_WAIT   = 4'd0;
    localparam pc_t PC_MUL_P  = 4'd1;
    localparam pc_t PC_MUL_Q  = 4'd2;
    localparam pc_t PC_MUL_D  = 4'd3;
    localparam pc_t PC_SUM    = 4'd4;
    localparam pc_t PC_GINIT  = 4'd5;
    localparam pc_t PC_GSHIFT = 4'd6;
    localparam pc_t PC_GSTEP  = 4'd7;
    localparam pc_t PC_DINIT  = 4'd8;
    localparam pc_t PC_DSTEP  = 4'd9;
    localparam pc_t PC_OK     = 4'd10;
    localparam pc_t PC_ERR    = 4'd11;
    localparam pc_t PC_ZERO   = 4'd12;

    // Control store: one word per step, jump to target when the condition holds.
    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        unique case (pc)
            PC_WAIT:   w = '{op: OP_LOAD,      cond: C_IDLE,      target: PC_WAIT};
            PC_MUL_P:  w = '{op: OP_MUL_P,     cond: C_DEN_ZERO,  target: PC_ERR};
            PC_MUL_Q:  w = '{op: OP_MUL_Q,     cond: C_NEVER,     target: PC_WAIT};
            PC_MUL_D:  w = '{op: OP_MUL_D,     cond: C_NEVER,     target: PC_WAIT};
            PC_SUM:    w = '{op: OP_SUM,       cond: C_NEVER,     target: PC_WAIT};
            PC_GINIT:  w = '{op: OP_GINIT,     cond: C_MAG_ZERO,  target: PC_ZERO};
            PC_GSHIFT: w = '{op: OP_GSHIFT,    cond: C_BOTH_EVEN, target: PC_GSHIFT};
            PC_GSTEP:  w = '{op: OP_GSTEP,     cond: C_A_NONZERO, target: PC_GSTEP};
            PC_DINIT:  w = '{op: OP_DINIT,     cond: C_NEVER,     target: PC_WAIT};
            PC_DSTEP:  w = '{op: OP_DSTEP,     cond: C_DIV_MORE,  target: PC_DSTEP};
            PC_OK:     w = '{op: OP_EMIT_OK,   cond: C_ALWAYS,    target: PC_WAIT};
            PC_ERR:    w = '{op: OP_EMIT_ERR,  cond: C_ALWAYS,    target: PC_WAIT};
            PC_ZERO:   w = '{op: OP_EMIT_ZERO, cond: C_ALWAYS,    target: PC_WAIT};
            default:   w = '{op: OP_LOAD,      cond: C_ALWAYS,    target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/fraction_add_reduce.sv
// Top level of the fraction adder: sums two fractions and reduces the result.
//
//   Channel   Direction  Handshake               Ports
//   item in   input      start high, busy low    num_a, den_a, num_b, den_b
//   result    output     done strobe, one cycle  status, red_num, red_den, is_whole
//
// The run time of an item is set by the binary gcd loop, one step per cycle over 32-bit
// magnitudes, and by the two restoring dividers that run side by side. A zero denominator
// ends the item early with an error, and a zero sum ends it early with 0/1. Reset clears the
// step counter and the done strobe only. A new item may be started in the cycle in which
// done is high; the receiver cannot stall a result.
`timescale 1ns / 1ps
`include "fraction_add_reduce_macros.svh"

module fraction_add_reduce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [far_pkg::WIDTH-1:0]    num_a,
    input  logic signed [far_pkg::WIDTH-1:0]    den_a,
    input  logic signed [far_pkg::WIDTH-1:0]    num_b,
    input  logic signed [far_pkg::WIDTH-1:0]    den_b,
    output logic                                busy,
    output logic                                done,
    output logic                                status,
    output logic signed [far_pkg::PROD_W-1:0]   red_num,
    output logic        [far_pkg::DEN_W-1:0]    red_den,
    output logic                                is_whole
);

    far_pkg::uword_t ctrl;
    far_pkg::flags_t flags;

    far_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    far_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .num_a    (num_a),
        .den_a    (den_a),
        .num_b    (num_b),
        .den_b    (den_b),
        .flags    (flags),
        .done     (done),
        .status   (status),
        .red_num  (red_num),
        .red_den  (red_den),
        .is_whole (is_whole)
    );

    `FAR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `FAR_ASSERT_SAME(a_done_after_busy, done, $past(busy))
    `FAR_ASSERT_SAME(a_err_fields, done && status, red_num == '0 && red_den == '0 && !is_whole)
    `FAR_ASSERT_SAME(a_ok_den, done && !status, red_den != '0)
    `FAR_ASSERT_SAME(a_whole_den, done && is_whole, red_den == far_pkg::DEN_W'(1))

endmodule

FILE: hw/rtl/far_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module far_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  far_pkg::flags_t  flags,
    output far_pkg::uword_t  ctrl,
    output logic             busy
);

    far_pkg::pc_t    pc_reg;
    far_pkg::pc_t    pc_next;
    far_pkg::uword_t uw;
    logic            take;

    assign uw = far_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (uw.cond)
            far_pkg::C_NEVER:     take = 1'b0;
            far_pkg::C_ALWAYS:    take = 1'b1;
            far_pkg::C_IDLE:      take = !start;
            far_pkg::C_DEN_ZERO:  take = flags.den_zero;
            far_pkg::C_MAG_ZERO:  take = flags.mag_zero;
            far_pkg::C_BOTH_EVEN: take = flags.both_even;
            far_pkg::C_A_NONZERO: take = flags.a_nonzero;
            far_pkg::C_DIV_MORE:  take = flags.div_more;
            default:              take = 1'b0;
        endcase
        pc_next = take ? uw.target : far_pkg::pc_t'(pc_reg + 1'b1);
    end

    always_comb
    begin
        ctrl = uw;
        busy = (pc_reg != far_pkg::PC_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= far_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hw/rtl/far_datapath.sv
// Datapath: shared multiplier, magnitude adder, binary gcd unit and two restoring dividers.
`timescale 1ns / 1ps

module far_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  far_pkg::uword_t                     ctrl,
    input  logic signed [far_pkg::WIDTH-1:0]    num_a,
    input  logic signed [far_pkg::WIDTH-1:0]    den_a,
    input  logic signed [far_pkg::WIDTH-1:0]    num_b,
    input  logic signed [far_pkg::WIDTH-1:0]    den_b,
    output far_pkg::flags_t                     flags,
    output logic                                done,
    output logic                                status,
    output logic signed [far_pkg::PROD_W-1:0]   red_num,
    output logic        [far_pkg::DEN_W-1:0]    red_den,
    output logic                                is_whole
);

    localparam int W  = far_pkg::WIDTH;
    localparam int PW = far_pkg::PROD_W;
    localparam int RW = far_pkg::REM_W;
    localparam int SW = far_pkg::SHIFT_W;
    localparam int CW = far_pkg::CNT_W;

    logic [W-1:0]  na_reg, da_reg, nb_reg, db_reg;
    logic          sp_reg, sq_reg, neg_reg;
    logic [PW-1:0] p_reg, q_reg, d_reg, mag_reg;
    logic [PW-1:0] ga_reg, gb_reg, g_reg;
    logic [SW-1:0] k_reg;
    logic [PW-1:0] qm_reg, qd_reg;
    logic [RW-1:0] rm_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    logic          done_reg, done_next;
    logic          status_reg;
    logic [PW-1:0] red_num_reg;
    logic [far_pkg::DEN_W-1:0] red_den_reg;
    logic          is_whole_reg;

    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [RW-1:0] rm_sh, rd_sh, g_ext;
    logic          bm, bd;

    function automatic logic [W-1:0] magnitude(logic [W-1:0] v);
        return v[W-1] ? W'(~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        unique case (ctrl.op)
            far_pkg::OP_MUL_P:
            begin
                mul_a = na_reg;
                mul_b = db_reg;
            end
            far_pkg::OP_MUL_Q:
            begin
                mul_a = nb_reg;
                mul_b = da_reg;
            end
            default:
            begin
                mul_a = da_reg;
                mul_b = db_reg;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        g_ext = RW'(g_reg);
        rm_sh = {rm_reg[RW-2:0], qm_reg[PW-1]};
        rd_sh = {rd_reg[RW-2:0], qd_reg[PW-1]};
        bm    = (rm_sh >= g_ext);
        bd    = (rd_sh >= g_ext);
    end

    always_comb
    begin
        flags.den_zero  = (da_reg == '0) || (db_reg == '0);
        flags.mag_zero  = (mag_reg == '0);
        flags.both_even = !ga_reg[0] && !gb_reg[0];
        flags.a_nonzero = (ga_reg != '0);
        flags.div_more  = (cnt_reg != CW'(PW - 1));
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            far_pkg::OP_LOAD:
            begin
                na_reg <= magnitude(num_a);
                da_reg <= magnitude(den_a);
                nb_reg <= magnitude(num_b);
                db_reg <= magnitude(den_b);
                sp_reg <= num_a[W-1] ^ den_a[W-1] ^ den_b[W-1];
                sq_reg <= num_b[W-1] ^ den_b[W-1] ^ den_a[W-1];
            end
            far_pkg::OP_MUL_P: p_reg <= prod;
            far_pkg::OP_MUL_Q: q_reg <= prod;
            far_pkg::OP_MUL_D: d_reg <= prod;
            far_pkg::OP_SUM:
            begin
                if (sp_reg == sq_reg)
                begin
                    mag_reg <= p_reg + q_reg;
                    neg_reg <= sp_reg;
                end
                else if (p_reg >= q_reg)
                begin
                    mag_reg <= p_reg - q_reg;
                    neg_reg <= sp_reg;
                end
                else
                begin
                    mag_reg <= q_reg - p_reg;
                    neg_reg <= sq_reg;
                end
            end
            far_pkg::OP_GINIT:
            begin
                ga_reg <= mag_reg;
                gb_reg <= d_reg;
                k_reg  <= '0;
            end
            far_pkg::OP_GSHIFT:
            begin
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    k_reg  <= SW'(k_reg + 1'b1);
                end
            end
            far_pkg::OP_GSTEP:
            begin
                if (ga_reg != '0)
                begin
                    priority if (!ga_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                    end
                    else if (!gb_reg[0])
                    begin
                        gb_reg <= gb_reg >> 1;
                    end
                    else if (ga_reg >= gb_reg)
                    begin
                        ga_reg <= (ga_reg - gb_reg) >> 1;
                    end
                    else
                    begin
                        gb_reg <= (gb_reg - ga_reg) >> 1;
                    end
                end
            end
            far_pkg::OP_DINIT:
            begin
                g_reg   <= gb_reg << k_reg;
                qm_reg  <= mag_reg;
                qd_reg  <= d_reg;
                rm_reg  <= '0;
                rd_reg  <= '0;
                cnt_reg <= '0;
            end
            far_pkg::OP_DSTEP:
            begin
                rm_reg  <= bm ? RW'(rm_sh - g_ext) : rm_sh;
                rd_reg  <= bd ? RW'(rd_sh - g_ext) : rd_sh;
                qm_reg  <= {qm_reg[PW-2:0], bm};
                qd_reg  <= {qd_reg[PW-2:0], bd};
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            far_pkg::OP_EMIT_OK:
            begin
                status_reg   <= 1'b0;
                red_num_reg  <= neg_reg ? PW'(~qm_reg + 1'b1) : qm_reg;
                red_den_reg  <= qd_reg[far_pkg::DEN_W-1:0];
                is_whole_reg <= (qd_reg == PW'(1));
            end
            far_pkg::OP_EMIT_ERR:
            begin
                status_reg   <= 1'b1;
                red_num_reg  <= '0;
                red_den_reg  <= '0;
                is_whole_reg <= 1'b0;
            end
            far_pkg::OP_EMIT_ZERO:
            begin
                status_reg   <= 1'b0;
                red_num_reg  <= '0;
                red_den_reg  <= far_pkg::DEN_W'(1);
                is_whole_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign done_next = (ctrl.op == far_pkg::OP_EMIT_OK) ||
                       (ctrl.op == far_pkg::OP_EMIT_ERR) ||
                       (ctrl.op == far_pkg::OP_EMIT_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign red_num  = $signed(red_num_reg);
    assign red_den  = red_den_reg;
    assign is_whole = is_whole_reg;

endmodule
